/* rtl/core/periodic_lattice_neighbor_index_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the lattice neighbor index block
// Clocked property checks; they compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_LATTICE_NEIGHBOR_INDEX_ASSERT_SVH
`define PERIODIC_LATTICE_NEIGHBOR_INDEX_ASSERT_SVH

`ifndef SYNTHESIS
`define PLNI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PLNI_ASSERT_VLD(lbl, clk, rstn, vld, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (vld) |-> (cond)) else $error(msg);
`else
`define PLNI_ASSERT(lbl, clk, rstn, prop, msg)
`define PLNI_ASSERT_VLD(lbl, clk, rstn, vld, cond, msg)
`endif

`endif

/* rtl/core/plni_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plni_pkg
// Shared widths, reset values, register codes and helpers.
// ---------------------------------------------------------------------------
package plni_pkg;

  localparam int MAX_DIMS_DEF = 4;
  localparam int MAX_SIDE_DEF = 256;

  localparam int SITE_W     = 32;
  localparam int DIR_W      = 3;
  localparam int LEN_W      = 8;
  localparam int BOND_W     = 34;
  localparam int PW_W       = 34;
  localparam int DIMS_W     = 3;
  localparam int SIDE_W     = 9;
  localparam int CFG_DATA_W = 9;

  localparam int DIMS_RST = 2;
  localparam int SIDE_RST = 16;

  // quotient bits resolved per divider stage
  localparam int DIV_STEPS = 8;

  localparam logic [PW_W-1:0] VOL_CAP = 34'h2_0000_0000;

  typedef enum logic [0:0] {
    REG_DIMS = 1'b0,
    REG_SIDE = 1'b1
  } cfg_reg_t;

  // base**k, saturated at the volume cap
  function automatic logic [PW_W-1:0] pow_sat(input int unsigned base, input int unsigned k);
    logic [PW_W+31:0] acc;
    acc = (PW_W+32)'(1);
    for (int unsigned i = 0; i < k; i++) begin
      acc = acc * (PW_W+32)'(base);
      if (acc > (PW_W+32)'(VOL_CAP)) begin
        acc = (PW_W+32)'(VOL_CAP);
      end
    end
    return acc[PW_W-1:0];
  endfunction

endpackage

/* rtl/core/plni_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plni channel interfaces
// Valid/ready channels for site queries and neighbor results.
// ---------------------------------------------------------------------------
interface plni_in_if import plni_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] site;
  logic [DIR_W-1:0]  dir;
  logic [LEN_W-1:0]  length;
  logic [SITE_W-1:0] other_site;

  modport source (output valid, output site, output dir, output length,
                  output other_site, input ready);
  modport sink   (input valid, input site, input dir, input length,
                  input other_site, output ready);
endinterface

interface plni_out_if import plni_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] offset_site;
  logic [BOND_W-1:0] bond_index;
  logic              parity_odd;
  logic [DIR_W-1:0]  found_dir;
  logic              dir_found;
  logic              range_error;

  modport source (output valid, output offset_site, output bond_index,
                  output parity_odd, output found_dir, output dir_found,
                  output range_error, input ready);
  modport sink   (input valid, input offset_site, input bond_index,
                  input parity_odd, input found_dir, input dir_found,
                  input range_error, output ready);
endinterface

/* rtl/core/plni_geom.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// plni_geom
// Configuration registers and derived lattice geometry (axis weights, volume).
// ---------------------------------------------------------------------------
module plni_geom import plni_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int LW       = $clog2(MAX_SIDE + 1),
  parameter int DW       = $clog2(MAX_DIMS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [DW-1:0]         eff_d,
  output logic [LW-1:0]         eff_side,
  output logic [PW_W-1:0]       pw [MAX_DIMS+1],
  output logic [PW_W-1:0]       lm [MAX_DIMS],
  output logic [PW_W-1:0]       vol
);

  localparam int L0 = (SIDE_RST > MAX_SIDE) ? MAX_SIDE : SIDE_RST;
  localparam int D0 = (DIMS_RST > MAX_DIMS) ? MAX_DIMS : DIMS_RST;

  logic [DIMS_W-1:0] dims_r;
  logic [SIDE_W-1:0] side_r;
  logic [PW_W-1:0]   pw_r   [1:MAX_DIMS];
  logic [PW_W-1:0]   pw_nxt [1:MAX_DIMS];
  logic [PW_W-1:0]   lm_r   [MAX_DIMS];
  logic [PW_W-1:0]   lm_nxt [MAX_DIMS];
  logic [PW_W-1:0]   vol_r;
  logic [PW_W-1:0]   vol_nxt;

  always_comb begin
    if (dims_r == '0) begin
      eff_d = DW'(1);
    end else if (int'(dims_r) > MAX_DIMS) begin
      eff_d = DW'(MAX_DIMS);
    end else begin
      eff_d = DW'(dims_r);
    end
    if (int'(side_r) < 2) begin
      eff_side = LW'(2);
    end else if (int'(side_r) > MAX_SIDE) begin
      eff_side = LW'(MAX_SIDE);
    end else begin
      eff_side = LW'(side_r);
    end
  end

  always_comb begin
    pw[0] = PW_W'(1);
    for (int k = 1; k <= MAX_DIMS; k++) begin
      pw[k] = pw_r[k];
    end
  end

  // each weight is registered from the one below it, so it follows that weight in the next cycle
  always_comb begin
    logic [PW_W+LW-1:0] prod;
    for (int k = 1; k <= MAX_DIMS; k++) begin
      prod = (PW_W+LW)'(pw[k-1]) * (PW_W+LW)'(eff_side);
      pw_nxt[k] = (prod > (PW_W+LW)'(VOL_CAP)) ? VOL_CAP : prod[PW_W-1:0];
    end
    for (int j = 0; j < MAX_DIMS; j++) begin
      lm_nxt[j] = PW_W'((PW_W+LW)'(pw[j]) * (PW_W+LW)'(eff_side - LW'(1)));
    end
    vol_nxt = pw[eff_d];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_W'(DIMS_RST);
      side_r <= SIDE_W'(SIDE_RST);
      for (int k = 1; k <= MAX_DIMS; k++) begin
        pw_r[k] <= pow_sat(L0, k);
      end
      for (int j = 0; j < MAX_DIMS; j++) begin
        lm_r[j] <= PW_W'(64'(L0 - 1) * 64'(pow_sat(L0, j)));
      end
      vol_r <= pow_sat(L0, D0);
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_DIMS: dims_r <= cfg_wdata[DIMS_W-1:0];
          REG_SIDE: side_r <= cfg_wdata[SIDE_W-1:0];
        endcase
      end
      pw_r  <= pw_nxt;
      lm_r  <= lm_nxt;
      vol_r <= vol_nxt;
    end
  end

  assign lm  = lm_r;
  assign vol = vol_r;

endmodule

/* rtl/core/plni_div.sv */
`timescale 1ns / 1ps
`include "periodic_lattice_neighbor_index_assert.svh"
// ---------------------------------------------------------------------------
// plni_div
// Pipelined restoring divider by the side length, with a sideband payload.
// ---------------------------------------------------------------------------
module plni_div import plni_pkg::*; #(
  parameter int LW    = 9,
  parameter int AUX_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  logic [SITE_W-1:0] in_num,
  input  logic [LW-1:0]     divisor,
  input  logic [AUX_W-1:0]  in_aux,
  output logic              out_v,
  output logic [SITE_W-1:0] out_q,
  output logic [LW-1:0]     out_r,
  output logic [AUX_W-1:0]  out_aux
);

  localparam int NSTG = SITE_W / DIV_STEPS;

  logic              v_r     [NSTG];
  logic [SITE_W-1:0] num_r   [NSTG];
  logic [SITE_W-1:0] num_nxt [NSTG];
  logic [SITE_W-1:0] num_src [NSTG];
  logic [LW-1:0]     rem_r   [NSTG];
  logic [LW-1:0]     rem_nxt [NSTG];
  logic [LW-1:0]     rem_src [NSTG];
  logic [AUX_W-1:0]  aux_r   [NSTG];

  always_comb begin
    num_src[0] = in_num;
    rem_src[0] = '0;
    for (int s = 1; s < NSTG; s++) begin
      num_src[s] = num_r[s-1];
      rem_src[s] = rem_r[s-1];
    end
  end

  // shift the dividend through the remainder, quotient bits fill from the bottom
  always_comb begin
    logic [SITE_W-1:0] n;
    logic [LW-1:0]     r;
    logic [LW:0]       w;
    for (int s = 0; s < NSTG; s++) begin
      n = num_src[s];
      r = rem_src[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        w = {r, n[SITE_W-1]};
        n = {n[SITE_W-2:0], 1'b0};
        if (w >= {1'b0, divisor}) begin
          r    = LW'(w - {1'b0, divisor});
          n[0] = 1'b1;
        end else begin
          r = w[LW-1:0];
        end
      end
      num_nxt[s] = n;
      rem_nxt[s] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_v;
      for (int s = 1; s < NSTG; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r    <= num_nxt;
      rem_r    <= rem_nxt;
      aux_r[0] <= in_aux;
      for (int s = 1; s < NSTG; s++) begin
        aux_r[s] <= aux_r[s-1];
      end
    end
  end

  assign out_v   = v_r[NSTG-1];
  assign out_q   = num_r[NSTG-1];
  assign out_r   = rem_r[NSTG-1];
  assign out_aux = aux_r[NSTG-1];

  `PLNI_ASSERT_VLD(a_rem_below_div, clk, rst_n, out_v, out_r < divisor, "remainder not below divisor")
  `PLNI_ASSERT(a_enter_stage, clk, rst_n, adv && in_v |=> v_r[0], "transaction lost at divider entry")
  `PLNI_ASSERT(a_stall_hold, clk, rst_n, !adv && out_v |=> out_v && $stable(out_r), "divider moved while stalled")

endmodule

/* rtl/core/plni_nbr.sv */
`timescale 1ns / 1ps
`include "periodic_lattice_neighbor_index_assert.svh"
// ---------------------------------------------------------------------------
// plni_nbr
// Offset, bond, parity and neighbor search over the extracted digits.
// ---------------------------------------------------------------------------
module plni_nbr import plni_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int LW       = 9,
  parameter int DW       = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  logic [SITE_W-1:0] site,
  input  logic [SITE_W-1:0] other_site,
  input  logic [DIR_W-1:0]  dir,
  input  logic [LEN_W-1:0]  length,
  input  logic [LW-1:0]     digit [MAX_DIMS],
  input  logic [DW-1:0]     eff_d,
  input  logic [LW-1:0]     eff_side,
  input  logic [PW_W-1:0]   pw [MAX_DIMS+1],
  input  logic [PW_W-1:0]   lm [MAX_DIMS],
  input  logic [PW_W-1:0]   vol,
  output logic              out_v,
  output logic [SITE_W-1:0] offset_site,
  output logic [BOND_W-1:0] bond_index,
  output logic              parity_odd,
  output logic [DIR_W-1:0]  found_dir,
  output logic              dir_found,
  output logic              range_error
);

  localparam int JW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int XW = ((DW + 1 > DIR_W) ? DW + 1 : DIR_W) + 1;
  localparam int TW = ((LW > LEN_W) ? LW : LEN_W) + 2;
  localparam int PRW = TW + 1 + PW_W + 1;

  // stage 1: digit move, range check, parity, all nearest neighbors
  logic [XW-1:0]     dir_x, d_x, j_x;
  logic              fwd;
  logic [JW-1:0]     jsel, ax;
  logic [LW-1:0]     c;
  logic [TW-1:0]     t, c_x, len_x, l_x;
  logic signed [TW:0] delta;
  logic              par, err;
  logic [PW_W-1:0]   nbf [MAX_DIMS];
  logic [PW_W-1:0]   nbb [MAX_DIMS];

  always_comb begin
    dir_x = XW'(dir);
    d_x   = XW'(eff_d);
    fwd   = dir_x < d_x;
    j_x   = fwd ? (d_x - dir_x - XW'(1)) : (dir_x - d_x);
    jsel  = JW'(j_x);
    ax    = fwd ? JW'(dir_x) : JW'(d_x - XW'(1) - j_x);
    c     = digit[jsel];
    c_x   = TW'(c);
    len_x = TW'(length);
    l_x   = TW'(eff_side);
    if (fwd) begin
      t = c_x + len_x;
      if (t >= l_x) begin
        t = t - l_x;
      end
    end else if (c_x >= len_x) begin
      t = c_x - len_x;
    end else begin
      t = c_x + l_x - len_x;
    end
    delta = $signed({1'b0, t}) - $signed({1'b0, c_x});
    err = ({2'b0, site} >= vol) || ({2'b0, other_site} >= vol) ||
          (dir_x >= (d_x << 1)) || (len_x >= l_x);
    par = 1'b0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (j < int'(eff_d)) begin
        par = par ^ digit[j][0];
      end
    end
    for (int j = 0; j < MAX_DIMS; j++) begin
      nbf[j] = (digit[j] == LW'(eff_side - LW'(1))) ? ({2'b0, site} - lm[j])
                                                      : ({2'b0, site} + pw[j]);
      nbb[j] = (digit[j] == '0) ? ({2'b0, site} + lm[j]) : ({2'b0, site} - pw[j]);
    end
  end

  logic              e1_v_r;
  logic [SITE_W-1:0] e1_site_r, e1_other_r;
  logic              e1_fwd_r, e1_par_r, e1_err_r;
  logic [JW-1:0]     e1_jsel_r, e1_ax_r;
  logic signed [TW:0] e1_delta_r;
  logic [PW_W-1:0]   e1_nbf_r [MAX_DIMS];
  logic [PW_W-1:0]   e1_nbb_r [MAX_DIMS];

  // stage 2: weight multiply, bond base, neighbor compares
  logic signed [PRW-1:0] prod;
  logic [SITE_W-1:0]     off_add;
  logic [BOND_W-1:0]     axv, base;
  logic [MAX_DIMS-1:0]   mf, mb;

  always_comb begin
    prod    = PRW'(e1_delta_r) * $signed({1'b0, pw[e1_jsel_r]});
    off_add = prod[SITE_W-1:0];
    axv     = BOND_W'((BOND_W+JW)'(e1_ax_r) * (BOND_W+JW)'(vol));
    base    = e1_fwd_r ? {2'b0, e1_site_r} : e1_nbb_r[e1_jsel_r];
    for (int j = 0; j < MAX_DIMS; j++) begin
      mf[j] = e1_nbf_r[j] == {2'b0, e1_other_r};
      mb[j] = e1_nbb_r[j] == {2'b0, e1_other_r};
    end
  end

  logic                e2_v_r;
  logic [SITE_W-1:0]   e2_site_r, e2_off_r;
  logic [BOND_W-1:0]   e2_axv_r, e2_base_r;
  logic                e2_par_r, e2_err_r;
  logic [MAX_DIMS-1:0] e2_mf_r, e2_mb_r;

  // stage 3: final sums and lowest matching direction
  logic             hit, found;
  logic [DIR_W-1:0] fd;

  always_comb begin
    found = 1'b0;
    fd    = '0;
    hit   = 1'b0;
    for (int i = 2 * MAX_DIMS - 1; i >= 0; i--) begin
      if (i < 2 * int'(eff_d)) begin
        if (i < int'(eff_d)) begin
          hit = e2_mf_r[int'(eff_d) - 1 - i];
        end else begin
          hit = e2_mb_r[i - int'(eff_d)];
        end
        if (hit) begin
          found = 1'b1;
          fd    = DIR_W'(i);
        end
      end
    end
  end

  logic              out_v_r;
  logic [SITE_W-1:0] off_r;
  logic [BOND_W-1:0] bond_r;
  logic              par_r, found_r, err_r;
  logic [DIR_W-1:0]  fd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r  <= 1'b0;
      e2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      e1_v_r  <= in_v;
      e2_v_r  <= e1_v_r;
      out_v_r <= e2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_site_r  <= site;
      e1_other_r <= other_site;
      e1_fwd_r   <= fwd;
      e1_jsel_r  <= jsel;
      e1_ax_r    <= ax;
      e1_delta_r <= delta;
      e1_par_r   <= par;
      e1_err_r   <= err;
      e1_nbf_r   <= nbf;
      e1_nbb_r   <= nbb;

      e2_site_r <= e1_site_r;
      e2_off_r  <= off_add;
      e2_axv_r  <= axv;
      e2_base_r <= base;
      e2_par_r  <= e1_par_r;
      e2_err_r  <= e1_err_r;
      e2_mf_r   <= mf;
      e2_mb_r   <= mb;

      // drop all result fields on a range error
      err_r   <= e2_err_r;
      off_r   <= e2_err_r ? '0 : (e2_site_r + e2_off_r);
      bond_r  <= e2_err_r ? '0 : (e2_axv_r + e2_base_r);
      par_r   <= e2_err_r ? 1'b0 : e2_par_r;
      found_r <= e2_err_r ? 1'b0 : found;
      fd_r    <= e2_err_r ? '0 : fd;
    end
  end

  assign out_v       = out_v_r;
  assign offset_site = off_r;
  assign bond_index  = bond_r;
  assign parity_odd  = par_r;
  assign found_dir   = fd_r;
  assign dir_found   = found_r;
  assign range_error = err_r;

  `PLNI_ASSERT_VLD(a_err_clean, clk, rst_n, out_v && range_error, !dir_found && offset_site == '0 && bond_index == '0, "range error with live result")
  `PLNI_ASSERT(a_e2_to_out, clk, rst_n, adv && e2_v_r |=> out_v, "transaction lost before output")
  `PLNI_ASSERT_VLD(a_found_in_range, clk, rst_n, out_v && dir_found, XW'(found_dir) < (XW'(eff_d) << 1), "found direction beyond lattice")

endmodule

/* rtl/core/periodic_lattice_neighbor_index.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_lattice_neighbor_index
// Neighbor, offset, bond and parity address generator for a periodic lattice.
// ---------------------------------------------------------------------------
//  port      | dir | carries
//  in_if     | in  | site, dir, length, other_site (valid/ready)
//  out_if    | out | offset_site, bond_index, parity_odd, found_dir,
//            |     | dir_found, range_error (valid/ready)
//  cfg_*     | in  | write enable, register index, data
//
//  One transaction per cycle while the output is not stalled; each one passes
//  the chain of MAX_DIMS-1 four-stage dividers by side length, then plni_nbr.
//  Reset is synchronous; after reset or a register write the derived axis
//  weights settle through the registered chain of axis weights.
//  A stall on the output freezes the whole pipeline and holds in_if.ready low.
// ---------------------------------------------------------------------------
module periodic_lattice_neighbor_index import plni_pkg::*; #(
  parameter int MAX_DIMS = MAX_DIMS_DEF,
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  cfg_reg_t              cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  plni_in_if.sink               in_if,
  plni_out_if.source            out_if
);

  localparam int LW    = $clog2(MAX_SIDE + 1);
  localparam int DW    = $clog2(MAX_DIMS + 1);
  localparam int NDIV  = MAX_DIMS - 1;
  localparam int DG_W  = MAX_DIMS * LW;
  localparam int AUX_W = 2 * SITE_W + DIR_W + LEN_W + DG_W;

  logic [DW-1:0]   eff_d;
  logic [LW-1:0]   eff_side;
  logic [PW_W-1:0] pw [MAX_DIMS+1];
  logic [PW_W-1:0] lm [MAX_DIMS];
  logic [PW_W-1:0] vol;
  logic            adv;

  plni_geom #(
    .MAX_DIMS (MAX_DIMS),
    .MAX_SIDE (MAX_SIDE),
    .LW       (LW),
    .DW       (DW)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .eff_d     (eff_d),
    .eff_side  (eff_side),
    .pw        (pw),
    .lm        (lm),
    .vol       (vol)
  );

  // advance whenever the output slot is free or being taken
  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  logic              v_c   [NDIV+1];
  logic [SITE_W-1:0] q_c   [NDIV+1];
  logic [AUX_W-1:0]  aux_c [NDIV+1];

  assign v_c[0]   = in_if.valid;
  assign q_c[0]   = in_if.site;
  assign aux_c[0] = {in_if.site, in_if.other_site, in_if.dir, in_if.length, DG_W'(0)};

  // each divider peels off the next least significant digit
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [LW-1:0]    rem;
    logic [AUX_W-1:0] aux_o;

    plni_div #(
      .LW    (LW),
      .AUX_W (AUX_W)
    ) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_v    (v_c[k]),
      .in_num  (q_c[k]),
      .divisor (eff_side),
      .in_aux  (aux_c[k]),
      .out_v   (v_c[k+1]),
      .out_q   (q_c[k+1]),
      .out_r   (rem),
      .out_aux (aux_o)
    );

    always_comb begin
      aux_c[k+1]               = aux_o;
      aux_c[k+1][k*LW +: LW]   = rem;
    end
  end

  logic [LW-1:0]     digit [MAX_DIMS];
  logic [SITE_W-1:0] site_e, other_e;
  logic [DIR_W-1:0]  dir_e;
  logic [LEN_W-1:0]  len_e;

  always_comb begin
    for (int j = 0; j < NDIV; j++) begin
      digit[j] = aux_c[NDIV][j*LW +: LW];
    end
    // the last quotient is the top digit when the site is in range
    digit[NDIV] = q_c[NDIV][LW-1:0];
  end

  assign site_e  = aux_c[NDIV][AUX_W-1 -: SITE_W];
  assign other_e = aux_c[NDIV][AUX_W-SITE_W-1 -: SITE_W];
  assign dir_e   = aux_c[NDIV][DIR_W+LEN_W+DG_W-1 -: DIR_W];
  assign len_e   = aux_c[NDIV][LEN_W+DG_W-1 -: LEN_W];

  plni_nbr #(
    .MAX_DIMS (MAX_DIMS),
    .LW       (LW),
    .DW       (DW)
  ) u_nbr (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_v        (v_c[NDIV]),
    .site        (site_e),
    .other_site  (other_e),
    .dir         (dir_e),
    .length      (len_e),
    .digit       (digit),
    .eff_d       (eff_d),
    .eff_side    (eff_side),
    .pw          (pw),
    .lm          (lm),
    .vol         (vol),
    .out_v       (out_if.valid),
    .offset_site (out_if.offset_site),
    .bond_index  (out_if.bond_index),
    .parity_odd  (out_if.parity_odd),
    .found_dir   (out_if.found_dir),
    .dir_found   (out_if.dir_found),
    .range_error (out_if.range_error)
  );

endmodule
